// ===== rtl/tic_pkg.sv =====
// Package for the terrain illumination cosine block.
// Holds sizes, register map, state encoding and small helpers.
// No dependencies.
package tic_pkg;

	localparam int MAX_WIDTH   = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int COL_BITS    = $clog2(MAX_WIDTH);
	localparam int WID_BITS    = 13;
	localparam int GRAD_BITS   = SAMPLE_BITS + 4;
	localparam int ADDR_BITS   = 5;

	// register indexes (byte address is 4*index)
	localparam logic [2:0] REG_IMAGE_WIDTH = 3'd0;
	localparam logic [2:0] REG_INV_EW      = 3'd1;
	localparam logic [2:0] REG_INV_NS      = 3'd2;
	localparam logic [2:0] REG_COS_ZENITH  = 3'd3;
	localparam logic [2:0] REG_SUN_EAST    = 3'd4;
	localparam logic [2:0] REG_SUN_NORTH   = 3'd5;

	typedef logic [SAMPLE_BITS:0] entry_t; // {null, sample}

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WIN,
		ST_GRAD,
		ST_SQR,
		ST_SUM,
		ST_SQRT,
		ST_DIVP,
		ST_DIV,
		ST_FIN,
		ST_DONE
	} tic_state_t;

	function automatic logic signed [GRAD_BITS-1:0] sx(input entry_t e);
		sx = GRAD_BITS'($signed(e[SAMPLE_BITS-1:0]));
	endfunction

endpackage

// ===== rtl/tic_if.sv =====
// Stream interfaces for elevation words in and illumination words out.
// Depends on tic_pkg for sizes.
interface tic_pix_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [tic_pkg::SAMPLE_BITS-1:0] elevation;
	logic                                  elev_null;
	logic                                  frame_start;
	modport source(output valid, elevation, elev_null, frame_start, input ready);
	modport sink(input valid, elevation, elev_null, frame_start, output ready);
endinterface

interface tic_shade_if;
	logic                               valid;
	logic                               ready;
	logic signed [15:0]                 cos_illum;
	logic                               out_null;
	logic [tic_pkg::COL_BITS-1:0]       centre_col;
	modport source(output valid, cos_illum, out_null, centre_col, input ready);
	modport sink(input valid, cos_illum, out_null, centre_col, output ready);
endinterface

// ===== rtl/terrain_illumination_cosine.sv =====
// Horn 3x3 hillshade illumination cosine over a streamed elevation raster.
// An interior non-null pixel goes through a 32-step square root and a 17-step divider
// before the output register; a null-window result skips both. One word at a time: the
// next word is taken only once the block is idle again, later while the output is full.
// Reset: async, active low; counters cleared, window null, registers at defaults;
// line store contents undefined until written.
module terrain_illumination_cosine (
	input  logic                        clk,
	input  logic                        arst_n,
	tic_pix_if.sink                     pixels,
	tic_shade_if.source                 shading,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tic_pkg::ADDR_BITS-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int CB = tic_pkg::COL_BITS;
	localparam int GB = tic_pkg::GRAD_BITS;

	// configuration
	logic [tic_pkg::WID_BITS-1:0] width_q;
	logic [23:0] ew_q, ns_q;
	logic [14:0] cz_q;
	logic signed [15:0] se_q, sn_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 13'd1024;
			ew_q    <= 24'd1048576;
			ns_q    <= 24'd1048576;
			cz_q    <= 15'd23170;
			se_q    <= 16'sd0;
			sn_q    <= 16'sd23170;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				tic_pkg::REG_IMAGE_WIDTH: width_q <= pwdata[12:0];
				tic_pkg::REG_INV_EW:      ew_q <= pwdata[23:0];
				tic_pkg::REG_INV_NS:      ns_q <= pwdata[23:0];
				tic_pkg::REG_COS_ZENITH:  cz_q <= pwdata[14:0];
				tic_pkg::REG_SUN_EAST:    se_q <= pwdata[15:0];
				tic_pkg::REG_SUN_NORTH:   sn_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			tic_pkg::REG_IMAGE_WIDTH: prdata = {19'd0, width_q};
			tic_pkg::REG_INV_EW:      prdata = {8'd0, ew_q};
			tic_pkg::REG_INV_NS:      prdata = {8'd0, ns_q};
			tic_pkg::REG_COS_ZENITH:  prdata = {17'd0, cz_q};
			tic_pkg::REG_SUN_EAST:    prdata = {16'd0, se_q};
			tic_pkg::REG_SUN_NORTH:   prdata = {16'd0, sn_q};
			default:                  prdata = 32'd0;
		endcase
	end

	// state machine
	tic_pkg::tic_state_t state_q, state_d;
	logic accept, has_res_q, nul_w, sqrt_last, div_last, out_load, ov_q;
	logic [4:0] cnt_q;

	assign accept = pixels.valid && pixels.ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tic_pkg::ST_IDLE: if (accept) state_d = tic_pkg::ST_WIN;
			tic_pkg::ST_WIN: begin
				if (!has_res_q)  state_d = tic_pkg::ST_IDLE;
				else if (nul_w)  state_d = tic_pkg::ST_DONE;
				else             state_d = tic_pkg::ST_GRAD;
			end
			tic_pkg::ST_GRAD: state_d = tic_pkg::ST_SQR;
			tic_pkg::ST_SQR:  state_d = tic_pkg::ST_SUM;
			tic_pkg::ST_SUM:  state_d = tic_pkg::ST_SQRT;
			tic_pkg::ST_SQRT: if (sqrt_last) state_d = tic_pkg::ST_DIVP;
			tic_pkg::ST_DIVP: state_d = tic_pkg::ST_DIV;
			tic_pkg::ST_DIV:  if (div_last) state_d = tic_pkg::ST_FIN;
			tic_pkg::ST_FIN:  state_d = tic_pkg::ST_DONE;
			tic_pkg::ST_DONE: if (out_load) state_d = tic_pkg::ST_IDLE;
			default:          state_d = tic_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		pixels.ready = (state_q == tic_pkg::ST_IDLE);
		out_load     = (state_q == tic_pkg::ST_DONE) && (!ov_q || shading.ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= tic_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	// counters
	logic [CB-1:0] col_q, col_cur, c_q;
	logic [1:0] row_q, row_cur;
	logic [tic_pkg::WID_BITS-1:0] wclamp;

	always_comb begin
		if (width_q < 13'd3)                  wclamp = 13'd3;
		else if (width_q > 13'(tic_pkg::MAX_WIDTH)) wclamp = 13'(tic_pkg::MAX_WIDTH);
		else                                  wclamp = width_q;
		col_cur = pixels.frame_start ? '0 : col_q;
		row_cur = pixels.frame_start ? 2'd0 : row_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q     <= '0;
			row_q     <= 2'd0;
			has_res_q <= 1'b0;
		end else if (accept) begin
			has_res_q <= (row_cur == 2'd2) && (col_cur >= CB'(2));
			if ({1'b0, col_cur} + 13'd1 >= wclamp) begin
				col_q <= '0;
				if (row_cur != 2'd2) row_q <= row_cur + 2'd1;
				else                 row_q <= row_cur;
			end else begin
				col_q <= col_cur + CB'(1);
				row_q <= row_cur;
			end
		end
	end

	// line store: one memory per buffered row
	tic_pkg::entry_t mid_mem [tic_pkg::MAX_WIDTH];
	tic_pkg::entry_t top_mem [tic_pkg::MAX_WIDTH];
	tic_pkg::entry_t mid_rd_q, top_rd_q, cur_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			mid_rd_q <= mid_mem[col_cur];
			top_rd_q <= top_mem[col_cur];
			cur_q    <= {pixels.elev_null, pixels.elevation};
			c_q      <= col_cur;
		end
		if (state_q == tic_pkg::ST_WIN) begin
			mid_mem[c_q] <= cur_q;
			top_mem[c_q] <= mid_rd_q;
		end
	end

	// window: entries 0..2 west column, 3..5 centre, north to south
	tic_pkg::entry_t win_q [6];
	tic_pkg::entry_t colv [9];

	always_comb begin
		for (int i = 0; i < 6; i++) colv[i] = win_q[i];
		colv[6] = top_rd_q;
		colv[7] = mid_rd_q;
		colv[8] = cur_q;
		nul_w = 1'b0;
		for (int i = 0; i < 9; i++) nul_w = nul_w | colv[i][tic_pkg::SAMPLE_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) win_q[i] <= {1'b1, {tic_pkg::SAMPLE_BITS{1'b0}}};
		end else if (state_q == tic_pkg::ST_WIN) begin
			for (int i = 0; i < 6; i++) win_q[i] <= colv[i+3];
		end
	end

	// arithmetic datapath
	logic signed [GB-1:0] gx_q, gy_q;
	logic signed [44:0] px, py;
	logic signed [31:0] dx_q, dy_q;
	logic [31:0] ax, ay;
	logic [63:0] sqx_q, sqy_q;
	logic signed [47:0] pe_q, pn_q;
	logic signed [49:0] num;
	logic neg_q;
	logic [48:0] mag_q;
	logic [63:0] x_q, r_q, bit_q, rb;
	logic [50:0] nn;
	logic [32:0] den_q;
	logic [33:0] part_q, tt;
	logic [16:0] nlow_q, q_q;
	logic ovf_q;
	logic signed [15:0] res_q;
	logic nulr_q;

	assign px   = gx_q * $signed({1'b0, ew_q});
	assign py   = gy_q * $signed({1'b0, ns_q});
	assign ax   = dx_q[31] ? (~dx_q + 32'd1) : dx_q;
	assign ay   = dy_q[31] ? (~dy_q + 32'd1) : dy_q;
	assign num  = $signed({11'd0, cz_q, 24'd0}) + 50'(pe_q) - 50'(pn_q);
	assign rb   = r_q + bit_q;
	assign sqrt_last = bit_q[0];
	assign nn   = {1'b0, mag_q, 1'b0} + {19'd0, r_q[31:0]};
	assign tt   = {part_q[32:0], nlow_q[16]};
	assign div_last = (cnt_q == 5'd16);

	function automatic logic signed [31:0] sat32(input logic signed [44:0] p);
		if (p[44:31] == '0 || p[44:31] == '1) sat32 = p[31:0];
		else if (p[44])                       sat32 = 32'sh8000_0000;
		else                                  sat32 = 32'sh7fff_ffff;
	endfunction

	always_ff @(posedge clk) begin
		unique case (state_q)
			tic_pkg::ST_WIN: begin
				gx_q <= (tic_pkg::sx(colv[0]) + (tic_pkg::sx(colv[1]) <<< 1) + tic_pkg::sx(colv[2]))
				      - (tic_pkg::sx(colv[6]) + (tic_pkg::sx(colv[7]) <<< 1) + tic_pkg::sx(colv[8]));
				gy_q <= (tic_pkg::sx(colv[0]) + (tic_pkg::sx(colv[3]) <<< 1) + tic_pkg::sx(colv[6]))
				      - (tic_pkg::sx(colv[2]) + (tic_pkg::sx(colv[5]) <<< 1) + tic_pkg::sx(colv[8]));
				res_q  <= 16'sd0;
				nulr_q <= 1'b1;
			end
			tic_pkg::ST_GRAD: begin
				dx_q <= sat32(px);
				dy_q <= sat32(py);
			end
			tic_pkg::ST_SQR: begin
				sqx_q <= ax * ax;
				sqy_q <= ay * ay;
				pe_q  <= se_q * dx_q;
				pn_q  <= sn_q * dy_q;
			end
			tic_pkg::ST_SUM: begin
				x_q   <= (64'd1 << 48) + sqx_q + sqy_q;
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
				neg_q <= num[49];
				mag_q <= num[49] ? 49'(-num) : num[48:0];
			end
			tic_pkg::ST_SQRT: begin
				if (x_q >= rb) begin
					x_q <= x_q - rb;
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			tic_pkg::ST_DIVP: begin
				den_q  <= {r_q[31:0], 1'b0};
				part_q <= nn[50:17];
				nlow_q <= nn[16:0];
				ovf_q  <= nn[50:17] >= {1'b0, r_q[31:0], 1'b0};
				q_q    <= '0;
				cnt_q  <= 5'd0;
			end
			tic_pkg::ST_DIV: begin
				if (tt >= {1'b0, den_q}) begin
					part_q <= tt - {1'b0, den_q};
					q_q    <= {q_q[15:0], 1'b1};
				end else begin
					part_q <= tt;
					q_q    <= {q_q[15:0], 1'b0};
				end
				nlow_q <= {nlow_q[15:0], 1'b0};
				cnt_q  <= cnt_q + 5'd1;
			end
			tic_pkg::ST_FIN: begin
				nulr_q <= 1'b0;
				if (neg_q) begin
					if (ovf_q || q_q >= 17'd32768) res_q <= -16'sd32768;
					else                            res_q <= 16'(-$signed({1'b0, q_q}));
				end else begin
					if (ovf_q || q_q >= 17'd32767) res_q <= 16'sd32767;
					else                            res_q <= q_q[15:0];
				end
			end
			default: ;
		endcase
	end

	// output register
	logic signed [15:0] ores_q;
	logic onul_q;
	logic [CB-1:0] ocol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)            ov_q <= 1'b0;
		else if (out_load)      ov_q <= 1'b1;
		else if (shading.ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ores_q <= res_q;
			onul_q <= nulr_q;
			ocol_q <= c_q - CB'(1);
		end
	end

	assign shading.valid      = ov_q;
	assign shading.cos_illum  = ores_q;
	assign shading.out_null   = onul_q;
	assign shading.centre_col = ocol_q;

`ifndef ASSERT_OFF
	a_accept_win: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == tic_pkg::ST_WIN) else $error("accept did not open window");
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		shading.valid && shading.out_null |-> shading.cos_illum == 16'sd0)
		else $error("null word carries value");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		shading.valid |-> shading.centre_col != '0 && shading.centre_col != '1)
		else $error("centre column out of range");
	a_row_sat: assert property (@(posedge clk) disable iff (!arst_n)
		row_q != 2'd3) else $error("row count beyond two");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == tic_pkg::ST_DIV |-> cnt_q <= 5'd16) else $error("divider overran");
`endif

endmodule
